[src/mwt_pkg.sv]
package mwt_pkg;

  localparam int unsigned SLOT_BITS  = 3;
  localparam int unsigned RING_DEPTH = 1 << SLOT_BITS;
  localparam int unsigned IN_WORD_BITS = 8;
  localparam int unsigned GAP_BITS   = 8;
  localparam logic [GAP_BITS-1:0] GAP_RESET = 8'd4;
  localparam int unsigned START_BITS = 2;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_START  = 4'b0001,
    ST_DATA   = 4'b0010,
    ST_GAP    = 4'b0100,
    ST_UNINIT = 4'b1000
  } frame_state_t;

  typedef struct packed {
    logic                    fire;
    cmd_t                    command;
    logic [SLOT_BITS-1:0]    slot;
    logic [IN_WORD_BITS-1:0] word;
  } step_t;

endpackage

[src/manchester_word_transmitter_top.sv]
// Manchester word transmitter.
// Input channel (in_valid / in_stall) carries one item per handshake: command 0
// is a half-bit tick, command 1 stores write_word into ring slot write_slot.
// Every item yields exactly one result on the output channel (out_valid /
// out_stall): line_level, copy_level and phase_high as they stand after it.
// A frame is a 1-0 start pair, the ring word at the read slot MSB first, then
// gap_bit_periods low bit periods, after which the read slot advances.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the gap
// length; cfg_ready is always high. Write it only while the block is idle.
// An accepted item waits in the input register, then the state update and the
// result valid land together on the edge on which it moves on.
// Throughput: one item per cycle while the output is not stalled, set by the frame state update.
// Reset: ring cleared, gap length 4, line low; the first tick re-initializes
// the frame without moving the lines. While out_stall is high the result
// holds, the input register fills and then in_stall rises.
module manchester_word_transmitter_top #(
  parameter int unsigned WORD_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [mwt_pkg::SLOT_BITS-1:0]    write_slot,
  input  logic [mwt_pkg::IN_WORD_BITS-1:0] write_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             line_level,
  output logic                             copy_level,
  output logic                             phase_high,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mwt_pkg::GAP_BITS-1:0]     cfg_data
);
  import mwt_pkg::*;

  logic                    s1_valid;
  cmd_t                    s1_command;
  logic [SLOT_BITS-1:0]    s1_slot;
  logic [IN_WORD_BITS-1:0] s1_word;
  logic                    advance;
  step_t                   step;
  logic [WORD_BITS+IN_WORD_BITS-1:0] word_ext;
  logic [WORD_BITS-1:0]    ring_wr_word, ring_rd_word;
  logic [SLOT_BITS-1:0]    read_slot;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_command <= cmd_t'(command);
      s1_slot    <= write_slot;
      s1_word    <= write_word;
    end
  end

  always_comb begin
    step.fire    = s1_valid && advance;
    step.command = s1_command;
    step.slot    = s1_slot;
    step.word    = s1_word;
  end

  // keep the stored word to WORD_BITS bits
  assign word_ext     = {{WORD_BITS{1'b0}}, s1_word};
  assign ring_wr_word = word_ext[WORD_BITS-1:0];

  mwt_ring #(.WORD_BITS(WORD_BITS)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (step.fire && step.command == CMD_WRITE),
    .wr_slot (step.slot),
    .wr_word (ring_wr_word),
    .rd_slot (read_slot),
    .rd_word (ring_rd_word)
  );

  mwt_core #(.WORD_BITS(WORD_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_gap   (cfg_data),
    .ring_word (ring_rd_word),
    .read_slot (read_slot),
    .line_reg  (line_level),
    .copy_reg  (copy_level),
    .phase     (phase_high)
  );

endmodule

[src/mwt_ring.sv]
module mwt_ring #(
  parameter int unsigned WORD_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [mwt_pkg::SLOT_BITS-1:0] wr_slot,
  input  logic [WORD_BITS-1:0]          wr_word,
  input  logic [mwt_pkg::SLOT_BITS-1:0] rd_slot,
  output logic [WORD_BITS-1:0]          rd_word
);
  import mwt_pkg::*;

  logic [WORD_BITS-1:0] ring [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else if (wr_en) begin
      ring[wr_slot] <= wr_word;
    end
  end

  assign rd_word = ring[rd_slot];

endmodule

[src/mwt_core.sv]
module mwt_core #(
  parameter int unsigned WORD_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mwt_pkg::step_t                step,
  input  logic                          cfg_we,
  input  logic [mwt_pkg::GAP_BITS-1:0]  cfg_gap,
  input  logic [WORD_BITS-1:0]          ring_word,
  output logic [mwt_pkg::SLOT_BITS-1:0] read_slot,
  output logic                          line_reg,
  output logic                          copy_reg,
  output logic                          phase
);
  import mwt_pkg::*;

  localparam int unsigned BL_BITS = $clog2(WORD_BITS + 1);
  localparam logic [BL_BITS-1:0] BL_FULL  = BL_BITS'(WORD_BITS);
  localparam logic [BL_BITS-1:0] BL_START = BL_BITS'(START_BITS);
  localparam logic [WORD_BITS-1:0] START_PAIR = {1'b1, {(WORD_BITS-1){1'b0}}};

  frame_state_t           frame_state, frame_state_next;
  logic                   phase_next;
  logic [WORD_BITS-1:0]   shift_word, shift_word_next;
  logic [BL_BITS-1:0]     bits_left, bits_left_next, bits_dec;
  logic [GAP_BITS-1:0]    gap_left, gap_left_next, gap_dec;
  logic [SLOT_BITS-1:0]   read_slot_next;
  logic                   line_next, copy_next;
  logic [GAP_BITS-1:0]    gap_bit_periods;
  logic                   msb, phase_t, do_restart;

  always_comb begin
    frame_state_next = frame_state;
    phase_next       = phase;
    shift_word_next  = shift_word;
    bits_left_next   = bits_left;
    gap_left_next    = gap_left;
    read_slot_next   = read_slot;
    line_next        = line_reg;
    copy_next        = copy_reg;
    do_restart       = 1'b0;
    phase_t          = ~phase;
    msb              = shift_word[WORD_BITS-1];
    bits_dec         = bits_left - 1'b1;
    gap_dec          = gap_left - 1'b1;

    if (step.fire && step.command == CMD_TICK) begin
      phase_next = phase_t;
      unique case (frame_state)
        ST_START, ST_DATA: begin
          if (phase_t) begin
            line_next = ~msb;
            copy_next = ~msb;
          end else begin
            line_next       = msb;
            copy_next       = msb;
            shift_word_next = {shift_word[WORD_BITS-2:0], 1'b0};
            bits_left_next  = bits_dec;
            if (bits_dec == '0) begin
              if (frame_state == ST_START) begin
                shift_word_next  = ring_word;
                bits_left_next   = BL_FULL;
                frame_state_next = ST_DATA;
              end else begin
                gap_left_next    = gap_bit_periods;
                frame_state_next = ST_GAP;
              end
            end
          end
        end
        ST_GAP: begin
          // copy line holds through the gap
          line_next = 1'b0;
          if (!phase_t) begin
            gap_left_next = gap_dec;
            if (gap_dec == '0) begin
              do_restart = 1'b1;
            end
          end
        end
        ST_UNINIT: begin
          do_restart = 1'b1;
        end
        default: begin
          do_restart = 1'b1;
        end
      endcase

      if (do_restart) begin
        shift_word_next  = START_PAIR;
        bits_left_next   = BL_START;
        frame_state_next = ST_START;
        phase_next       = 1'b0;
        read_slot_next   = read_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state     <= ST_UNINIT;
      phase           <= 1'b0;
      shift_word      <= '0;
      bits_left       <= '0;
      gap_left        <= '0;
      read_slot       <= '0;
      line_reg        <= 1'b0;
      copy_reg        <= 1'b0;
      gap_bit_periods <= GAP_RESET;
    end else begin
      frame_state <= frame_state_next;
      phase       <= phase_next;
      shift_word  <= shift_word_next;
      bits_left   <= bits_left_next;
      gap_left    <= gap_left_next;
      read_slot   <= read_slot_next;
      line_reg    <= line_next;
      copy_reg    <= copy_next;
      if (cfg_we) begin
        gap_bit_periods <= cfg_gap;
      end
    end
  end

  a_start_count: assert property (@(posedge clk) disable iff (rst)
    frame_state == ST_START |-> (bits_left == BL_START || bits_left == 1))
    else $error("start pair bit count out of range");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    frame_state == ST_DATA |-> (bits_left != '0 && bits_left <= BL_FULL))
    else $error("data bit count out of range");

  a_gap_copy_hold: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.command == CMD_TICK && frame_state == ST_GAP
      |=> $stable(copy_reg) && !line_reg)
    else $error("copy line moved or line high during gap");

  a_write_no_motion: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.command == CMD_WRITE
      |=> $stable(line_reg) && $stable(phase) && $stable(read_slot))
    else $error("ring write disturbed the transmitter");

endmodule
